### design/pulse_beat_detector_bpm_defines.svh
// Assertion macros used by the beat detector checker.
`ifndef PULSE_BEAT_DETECTOR_BPM_DEFINES_SVH
`define PULSE_BEAT_DETECTOR_BPM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/pbd_pkg.sv
// Types, constants and register codes of the pulse beat detector.
`timescale 1ns / 1ps
package pbd_pkg;

   localparam int unsigned TIME_BITS_DEF = 32;
   localparam int unsigned SAMPLE_BITS   = 10;
   localparam int unsigned BPM_BITS      = 16;
   localparam int unsigned INTERVAL_BITS = 16;
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 16;
   localparam int unsigned REQ_DATA_BITS = 16;
   localparam int unsigned RSP_DATA_BITS = 24;
   localparam int unsigned QUEUE_DEPTH   = 2;

   localparam logic [BPM_BITS-1:0] MS_PER_MINUTE = 16'd60000;

   // Result word layout, lowest bit first.
   localparam int unsigned RSP_LED_BIT   = 0;
   localparam int unsigned RSP_BEAT_BIT  = 1;
   localparam int unsigned RSP_VALID_BIT = 2;
   localparam int unsigned RSP_BPM_LSB   = 3;
   localparam int unsigned RSP_LOST_BIT  = RSP_BPM_LSB + BPM_BITS;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_THRESHOLD  = 3'd0,
      REG_REFRACTORY = 3'd1,
      REG_LED_ON     = 3'd2,
      REG_LOST_COUNT = 3'd3,
      REG_TICK       = 3'd4,
      REG_BPM_MIN    = 3'd5,
      REG_BPM_MAX    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [9:0]  threshold;
      logic [15:0] refractory_ms;
      logic [15:0] led_on_ms;
      logic [7:0]  lost_count;
      logic [9:0]  tick_ms;
      logic [15:0] bpm_min;
      logic [15:0] bpm_max;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      threshold:     10'd820,
      refractory_ms: 16'd800,
      led_on_ms:     16'd100,
      lost_count:    8'd10,
      tick_ms:       10'd20,
      bpm_min:       16'd40,
      bpm_max:       16'd200
   };

   // One classified sample on its way from the front end to the divider.
   typedef struct packed {
      logic                     led;
      logic                     beat;
      logic                     lost;
      logic [INTERVAL_BITS-1:0] interval;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_FIN
   } bk_state_type;

endpackage

### design/pbd_queue.sv
// Short queue of classified samples between the front end and the back end.
`timescale 1ns / 1ps
module pbd_queue #(
   parameter int unsigned DEPTH = pbd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pbd_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output pbd_pkg::item_type  pop_item,
   output logic               empty
);
   import pbd_pkg::*;

   localparam int unsigned PTR_BITS = $clog2(DEPTH);
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   item_type            entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff,  count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/pbd_front.sv
// Front end: tracks time, low runs, arming and the LED, and classifies each sample.
`timescale 1ns / 1ps
module pbd_front #(
   parameter int unsigned TIME_BITS = pbd_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pbd_pkg::cfg_type                  cfg,
   input  logic                              in_fire,
   input  logic [pbd_pkg::SAMPLE_BITS-1:0]   sample,
   output pbd_pkg::item_type                 item
);
   import pbd_pkg::*;

   logic [TIME_BITS-1:0] time_now_ff,   time_now_in;
   logic [TIME_BITS-1:0] last_beat_ff,  last_beat_in;
   logic [TIME_BITS-1:0] lit_at_ff,     lit_at_in;
   logic                 led_lit_ff,    led_lit_in;
   logic                 armed_ff,      armed_in;
   logic [7:0]           low_run_ff,    low_run_in;

   logic                 is_low, is_high, lost, beat;
   logic [TIME_BITS-1:0] since_beat, since_lit;

   always_comb begin
      is_low  = (sample < cfg.threshold);
      is_high = (sample > cfg.threshold);

      // The low run saturates at the lost count.
      if (is_low) begin
         low_run_in = (low_run_ff < cfg.lost_count) ? low_run_ff + 8'd1 : low_run_ff;
      end else begin
         low_run_in = '0;
      end
      lost = (low_run_in >= cfg.lost_count);

      since_beat = time_now_ff - last_beat_ff;
      since_lit  = time_now_ff - lit_at_ff;
      beat = !lost && is_high && armed_ff
             && (since_beat > TIME_BITS'(cfg.refractory_ms));

      last_beat_in = beat ? time_now_ff : last_beat_ff;
      lit_at_in    = beat ? time_now_ff : lit_at_ff;

      if (lost || beat) begin
         armed_in = 1'b0;
      end else begin
         armed_in = is_low ? 1'b1 : armed_ff;
      end

      // A fresh beat has zero elapsed LED time, so it stays lit unless the on time is zero.
      if (lost) begin
         led_lit_in = 1'b0;
      end else if (beat) begin
         led_lit_in = (cfg.led_on_ms != '0);
      end else begin
         led_lit_in = led_lit_ff && (since_lit < TIME_BITS'(cfg.led_on_ms));
      end

      time_now_in = time_now_ff + TIME_BITS'(cfg.tick_ms);

      item.led  = led_lit_in;
      item.beat = beat;
      item.lost = lost;
      // Any interval above the interval width gives a rate of zero, as does its clamp.
      item.interval = (since_beat > TIME_BITS'({INTERVAL_BITS{1'b1}}))
                      ? {INTERVAL_BITS{1'b1}} : since_beat[INTERVAL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff  <= '0;
         last_beat_ff <= '0;
         lit_at_ff    <= '0;
         led_lit_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         low_run_ff   <= '0;
      end else if (in_fire) begin
         time_now_ff  <= time_now_in;
         last_beat_ff <= last_beat_in;
         lit_at_ff    <= lit_at_in;
         led_lit_ff   <= led_lit_in;
         armed_ff     <= armed_in;
         low_run_ff   <= low_run_in;
      end
   end

endmodule

### design/pbd_back.sv
// Back end: divides the minute by the beat interval and holds the result register.
`timescale 1ns / 1ps
module pbd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  pbd_pkg::cfg_type                    cfg,
   input  logic                                q_empty,
   input  pbd_pkg::item_type                   q_item,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pbd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import pbd_pkg::*;

   localparam int unsigned STEP_BITS = $clog2(BPM_BITS);

   bk_state_type         state_ff, state_in;
   item_type             work_ff,  work_in;
   logic [BPM_BITS-1:0]  rem_ff,   rem_in;
   logic [BPM_BITS-1:0]  quo_ff,   quo_in;
   logic [STEP_BITS-1:0] step_ff,  step_in;
   logic                 out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;

   logic [BPM_BITS:0]    trial;
   logic [BPM_BITS-1:0]  bpm;
   logic                 out_free, out_load;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      state_in    = state_ff;
      work_in     = work_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      q_pop       = 1'b0;
      out_load    = 1'b0;
      out_free    = !out_valid_ff || rsp_tready;
      out_data_in = out_data_ff;

      // Restoring division: one quotient bit per cycle, most significant first.
      trial = {rem_ff, quo_ff[BPM_BITS-1]} - {1'b0, work_ff.interval};
      bpm   = work_ff.beat ? quo_ff : '0;

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               work_in  = q_item;
               rem_in   = '0;
               quo_in   = MS_PER_MINUTE;
               step_in  = '0;
               state_in = q_item.beat ? BK_DIV : BK_FIN;
            end
         end
         BK_DIV: begin
            if (trial[BPM_BITS]) begin
               rem_in = {rem_ff[BPM_BITS-2:0], quo_ff[BPM_BITS-1]};
            end else begin
               rem_in = trial[BPM_BITS-1:0];
            end
            quo_in  = {quo_ff[BPM_BITS-2:0], !trial[BPM_BITS]};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(BPM_BITS - 1)) begin
               state_in = BK_FIN;
            end
         end
         BK_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data_in = '0;
               out_data_in[RSP_LED_BIT]   = work_ff.led;
               out_data_in[RSP_BEAT_BIT]  = work_ff.beat;
               out_data_in[RSP_VALID_BIT] = work_ff.beat && (bpm >= cfg.bpm_min)
                                            && (bpm <= cfg.bpm_max);
               out_data_in[RSP_BPM_LSB +: BPM_BITS] = bpm;
               out_data_in[RSP_LOST_BIT]  = work_ff.lost;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
   end

endmodule

### design/pulse_beat_detector_bpm.sv
// Pulse beat detector top level: register file, front end, queue and divider back end.
//
// The req_ stream carries one pulse-sensor sample per transfer; each sample stands
// for one tick of tick_ms milliseconds. The rsp_ stream returns exactly one result
// per sample, in order: LED level, beat flag, BPM and its window flag, finger lost.
// The csr_ port writes the seven settings by index; write them only while idle.
//
// The front end classifies a sample in the cycle it is transferred and pushes it into
// a two-entry queue. The back end takes one entry at a time. A sample without a beat
// passes from the queue entry through the back end's work register into the result
// register; a beat also passes through the bit-serial divider that forms 60000 /
// interval. The back end takes no new entry until its last result is loaded, so
// the queue absorbs a short burst.
//
// The result register lets the back end finish the next item while a result waits.
// If rsp_tready stays low, the result holds, the queue fills and req_tready drops.
// Reset loads the default settings, zeroes time and beat history, turns the LED off,
// disarms the detector and empties the queue and the result register.
`timescale 1ns / 1ps
module pulse_beat_detector_bpm #(
   parameter int unsigned TIME_BITS = pbd_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample [9:0], zero fill above
   input  logic [pbd_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // led [0], beat [1], bpm_valid [2], bpm [18:3], finger_lost [19], zero fill above
   output logic [pbd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [pbd_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [pbd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import pbd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type front_item, q_item;
   logic     in_fire, q_full, q_empty, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_THRESHOLD:  cfg_in.threshold     = csr_wdata[9:0];
            REG_REFRACTORY: cfg_in.refractory_ms = csr_wdata;
            REG_LED_ON:     cfg_in.led_on_ms     = csr_wdata;
            REG_LOST_COUNT: cfg_in.lost_count    = csr_wdata[7:0];
            REG_TICK:       cfg_in.tick_ms       = csr_wdata[9:0];
            REG_BPM_MIN:    cfg_in.bpm_min       = csr_wdata;
            REG_BPM_MAX:    cfg_in.bpm_max       = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !q_full;
   assign in_fire    = req_tvalid && req_tready;

   pbd_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .in_fire (in_fire),
      .sample  (req_tdata[SAMPLE_BITS-1:0]),
      .item    (front_item)
   );

   pbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (in_fire),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   pbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### design/pbd_checker.sv
// Port-level checker for the pulse beat detector and its bind to the top level.
`timescale 1ns / 1ps
`include "pulse_beat_detector_bpm_defines.svh"
module pbd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic [pbd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready
);
   import pbd_pkg::*;

   logic r_led, r_beat, r_valid, r_lost, r_bpm_zero;

   assign r_led      = rsp_tdata[RSP_LED_BIT];
   assign r_beat     = rsp_tdata[RSP_BEAT_BIT];
   assign r_valid    = rsp_tdata[RSP_VALID_BIT];
   assign r_lost     = rsp_tdata[RSP_LOST_BIT];
   assign r_bpm_zero = (rsp_tdata[RSP_BPM_LSB +: BPM_BITS] == '0);

   // A stalled result stays offered and unchanged.
   `PBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // The window flag is only ever set together with a beat.
   `PBD_ASSERT_SAME(a_valid_needs_beat, clock, reset, rsp_tvalid && r_valid, r_beat, "bpm_valid without beat")

   // Finger lost rules out a beat, forces the LED off and leaves the rate field at zero.
   `PBD_ASSERT_SAME(a_lost_quiet, clock, reset, rsp_tvalid && r_lost, !r_beat && !r_led && r_bpm_zero, "finger lost with beat or LED")

   // Without a beat the rate field reads zero.
   `PBD_ASSERT_SAME(a_bpm_zero, clock, reset, rsp_tvalid && !r_beat, r_bpm_zero, "nonzero bpm without beat")

endmodule

bind pulse_beat_detector_bpm pbd_checker u_pbd_checker (.*);

### tb/sv/pulse_beat_detector_bpm_tb.sv
// Self-checking testbench for the pulse beat detector: stream stimulus, predictor and checks.
`timescale 1ns / 1ps
module pulse_beat_detector_bpm_tb;
   import pbd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 25;
   localparam int MAX_REPORTS    = 10;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SPARE = 3'd7;

   // One readout of the detector, as predicted or as seen on rsp_tdata.
   typedef struct packed {
      logic                led;
      logic                beat;
      logic                bpm_valid;
      logic [BPM_BITS-1:0] bpm;
      logic                lost;
   } readout_t;

   class beat_tracker;
      cfg_type     cfg;
      logic [31:0] now_ms;
      logic [31:0] last_beat_ms;
      logic [31:0] led_lit_ms;
      logic        led_lit;
      logic        armed;
      logic [7:0]  low_run;
      readout_t    expected_q[$];
      int          failures;
      int          readouts;
      int          beats;
      int          in_window;
      int          lost_seen;

      function new();
         cfg = CFG_RESET;
         now_ms = '0;
         last_beat_ms = '0;
         led_lit_ms = '0;
         led_lit = 1'b0;
         armed = 1'b0;
         low_run = '0;
         failures = 0;
         readouts = 0;
         beats = 0;
         in_window = 0;
         lost_seen = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
         case (idx)
            REG_THRESHOLD:  cfg.threshold = v[9:0];
            REG_REFRACTORY: cfg.refractory_ms = v;
            REG_LED_ON:     cfg.led_on_ms = v;
            REG_LOST_COUNT: cfg.lost_count = v[7:0];
            REG_TICK:       cfg.tick_ms = v[9:0];
            REG_BPM_MIN:    cfg.bpm_min = v;
            REG_BPM_MAX:    cfg.bpm_max = v;
            default: ;
         endcase
      endfunction

      // Advances the detector state by one sample and queues the readout it yields.
      function void note_sample(logic [SAMPLE_BITS-1:0] s);
         logic [31:0] gap;
         readout_t    r;
         r = '0;
         if (s < cfg.threshold) begin
            if (low_run < cfg.lost_count) low_run = low_run + 8'd1;
         end else begin
            low_run = '0;
         end
         if (low_run >= cfg.lost_count) begin
            led_lit = 1'b0;
            armed = 1'b0;
            r.lost = 1'b1;
            lost_seen++;
         end else begin
            if (s < cfg.threshold) armed = 1'b1;
            if (s > cfg.threshold && armed) begin
               gap = now_ms - last_beat_ms;
               if (gap > {16'd0, cfg.refractory_ms}) begin
                  armed = 1'b0;
                  last_beat_ms = now_ms;
                  led_lit_ms = now_ms;
                  led_lit = 1'b1;
                  r.beat = 1'b1;
                  r.bpm = 16'(32'd60000 / gap);
                  r.bpm_valid = (r.bpm >= cfg.bpm_min) && (r.bpm <= cfg.bpm_max);
                  beats++;
                  if (r.bpm_valid) in_window++;
               end
            end
            if (led_lit && (now_ms - led_lit_ms) >= {16'd0, cfg.led_on_ms}) led_lit = 1'b0;
         end
         now_ms = now_ms + {22'd0, cfg.tick_ms};
         r.led = led_lit;
         expected_q.push_back(r);
      endfunction

      function void check_readout(logic [RSP_DATA_BITS-1:0] w);
         readout_t got;
         readout_t want;
         got.led = w[RSP_LED_BIT];
         got.beat = w[RSP_BEAT_BIT];
         got.bpm_valid = w[RSP_VALID_BIT];
         got.bpm = w[RSP_BPM_LSB +: BPM_BITS];
         got.lost = w[RSP_LOST_BIT];
         readouts++;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("readout with nothing pending: tdata=%h", w);
            return;
         end
         want = expected_q.pop_front();
         if (got.led !== want.led || got.beat !== want.beat ||
             got.bpm_valid !== want.bpm_valid || got.bpm !== want.bpm ||
             got.lost !== want.lost) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("readout %0d mismatch: exp led=%0b beat=%0b valid=%0b bpm=%0d lost=%0b, got led=%0b beat=%0b valid=%0b bpm=%0d lost=%0b",
                        readouts, want.led, want.beat, want.bpm_valid, want.bpm, want.lost,
                        got.led, got.beat, got.bpm_valid, got.bpm, got.lost);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   beat_tracker tracker = new();
   bit idle_on;
   bit hold_go;
   int samples_sent;
   int settings_used;

   pulse_beat_detector_bpm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.note_sample(req_tdata[SAMPLE_BITS-1:0]);
         if (rsp_tvalid && rsp_tready) tracker.check_readout(rsp_tdata);
      end
   end

   // Result side: random stall bursts, plus one long hold-off that backs up the block.
   initial begin
      int  stall;
      int  hold;
      bit  hold_done;
      stall = 0;
      hold = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold = $urandom_range(120, 180);
         end
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else begin
            rsp_tready = 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 11);
         end
      end
   end

   // Ends the run when no transfer has happened on either stream for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {{(REQ_DATA_BITS - SAMPLE_BITS){1'b0}}, s};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] v);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = v;
      tracker.write_reg(idx, v);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Narrow registers get random junk above their width, which must be dropped.
   task automatic apply_settings(input int th, input int rf, input int lo, input int lc,
                                 input int tk, input int mn, input int mx);
      write_reg(REG_THRESHOLD, {6'($urandom), 10'(th)});
      write_reg(REG_REFRACTORY, 16'(rf));
      write_reg(REG_LED_ON, 16'(lo));
      write_reg(REG_LOST_COUNT, {8'($urandom), 8'(lc)});
      write_reg(REG_TICK, {6'($urandom), 10'(tk)});
      write_reg(REG_BPM_MIN, 16'(mn));
      write_reg(REG_BPM_MAX, 16'(mx));
      write_reg(REG_SPARE, 16'($urandom));
      settings_used++;
   endtask

   function automatic int maybe_limit(int v, int lo, int hi);
      if ($urandom_range(0, 9) != 0) return v;
      return ($urandom_range(0, 1) == 0) ? lo : hi;
   endfunction

   task automatic random_settings();
      int tk;
      int mn;
      tk = $urandom_range(1, 60);
      mn = $urandom_range(0, 150);
      apply_settings(maybe_limit($urandom_range(64, 960), 0, 1023),
                     maybe_limit(tk * $urandom_range(0, 30), 0, 65535),
                     maybe_limit(tk * $urandom_range(0, 12), 0, 65535),
                     maybe_limit($urandom_range(2, 24), 0, 255),
                     maybe_limit(tk, 0, 1023),
                     maybe_limit(mn, 0, 65535),
                     maybe_limit($urandom_range(mn, 600), 0, 65535));
   endtask

   function automatic logic [SAMPLE_BITS-1:0] low_level(int thr);
      return (thr == 0) ? '0 : SAMPLE_BITS'($urandom_range(0, thr - 1));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] high_level(int thr);
      return (thr >= 1023) ? '1 : SAMPLE_BITS'($urandom_range(thr + 1, 1023));
   endfunction

   task automatic end_phase();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly pulse shapes (a low run that arms, then a high peak) with noise,
   // samples sitting on the threshold and runs long enough to lose the finger.
   task automatic run_phase(input int n_items);
      int target;
      int kind;
      int thr;
      int run_max;
      target = samples_sent + n_items;
      while (samples_sent < target) begin
         thr = tracker.cfg.threshold;
         run_max = tracker.cfg.lost_count;
         kind = $urandom_range(0, 19);
         if (kind < 14) begin
            repeat ($urandom_range(1, (run_max > 1) ? ((run_max > 31) ? 30 : run_max - 1) : 1))
               push_sample(low_level(thr));
            repeat ($urandom_range(1, 4)) push_sample(high_level(thr));
         end else if (kind < 17) begin
            repeat ($urandom_range(1, 6)) push_sample(SAMPLE_BITS'($urandom_range(0, 1023)));
         end else if (kind < 19) begin
            repeat ($urandom_range(1, 3)) push_sample(SAMPLE_BITS'(thr));
         end else begin
            repeat (run_max + $urandom_range(0, 3)) push_sample(low_level(thr));
         end
      end
      end_phase();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      idle_on = 1'b0;
      hold_go = 1'b0;
      samples_sent = 0;
      settings_used = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Default settings: high while unarmed, on the threshold, a low run that
      // saturates into finger lost, then one just above the threshold.
      push_sample(10'd1023);
      push_sample(10'd820);
      repeat (11) push_sample(10'd0);
      push_sample(10'd821);
      end_phase();

      // Long ticks so beats come at once; zero LED time keeps the LED dark on a beat.
      apply_settings(820, 800, 0, 10, 1000, 0, 65535);
      push_sample(10'd819);
      push_sample(10'd1023);
      push_sample(10'd0);
      push_sample(10'd821);
      push_sample(10'd820);
      push_sample(10'd0);
      push_sample(10'd1023);
      end_phase();

      idle_on = 1'b1;
      apply_settings(1023, 0, 0, 255, 0, 0, 65535);
      run_phase(40);
      apply_settings(0, 65535, 65535, 0, 1023, 65535, 0);
      run_phase(30);
      apply_settings(512, 65535, 65535, 1, 1023, 0, 65535);
      run_phase(30);
      // Intervals beyond one minute give a beat with zero BPM.
      apply_settings(512, 65535, 65535, 255, 1023, 0, 0);
      run_phase(150);

      for (int p = 0; p < 8; p++) begin
         random_settings();
         idle_on = ($urandom_range(0, 3) != 0);
         if (p == 2) begin
            idle_on = 1'b1;
            hold_go = 1'b1;
         end
         run_phase(120);
      end

      idle_on = 1'b0;
      random_settings();
      run_phase(120);

      if (tracker.expected_q.size() != 0) begin
         tracker.failures += tracker.expected_q.size();
         $display("%0d readouts never arrived", tracker.expected_q.size());
      end
      $display("run covered %0d samples under %0d register settings, %0d readouts checked",
               samples_sent, settings_used, tracker.readouts);
      $display("beats %0d (in BPM window %0d), finger-lost readouts %0d, failures %0d",
               tracker.beats, tracker.in_window, tracker.lost_seen, tracker.failures);
      if (tracker.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/pbd_pkg.sv
design/pbd_queue.sv
design/pbd_front.sv
design/pbd_back.sv
design/pulse_beat_detector_bpm.sv
design/pbd_checker.sv
tb/sv/pulse_beat_detector_bpm_tb.sv
